// ===== sv/ospf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ospf_pkg;

    localparam int MAX_BINS_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int IDX_W     = 10;
    localparam int COUNT_W   = 11;
    localparam int SCALE_W   = 16;
    localparam int POWER_W   = 34;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int FRAC_W    = 16;

    localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;
    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd1311;
    localparam logic [COUNT_W-1:0] COUNT_MIN = 11'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_SCALE = 1'b1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic accept;
        logic fetch_a;
        logic fetch_b;
        logic square;
        logic add;
        logic scale;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic rd_err;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== sv/ospf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ospf_dp #(
    parameter int MAX_BINS    = ospf_pkg::MAX_BINS_DEF,
    parameter int SAMPLE_BITS = ospf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [ospf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ospf_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                                opcode,
    input  wire logic [ospf_pkg::IDX_W-1:0]          bin_index,
    input  wire logic signed [SAMPLE_BITS-1:0]       real_part,
    input  wire logic signed [SAMPLE_BITS-1:0]       imag_part,
    input  wire logic                                rsp_stall,
    output logic                                     rsp_valid,
    output logic [ospf_pkg::POWER_W-1:0]             power,
    output logic                                     index_error,
    input  wire ospf_pkg::cmd_t                      cmd,
    output ospf_pkg::sts_t                           sts
);

    localparam int AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int SB  = SAMPLE_BITS;
    localparam int DW  = 2 * SB;
    localparam int SQW = 2 * SB + 1;
    localparam int PW  = 2 * SB + 2;
    localparam int CW  = ospf_pkg::COUNT_W;
    localparam int FW  = ospf_pkg::FRAC_W;

    logic [CW-1:0]                bin_count_reg;
    logic [ospf_pkg::SCALE_W-1:0] power_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg   <= ospf_pkg::COUNT_RST;
            power_scale_reg <= ospf_pkg::SCALE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ospf_pkg::REG_BIN_COUNT)
                bin_count_reg <= CW'(cfg_data);
            else if (cfg_index == ospf_pkg::REG_POWER_SCALE)
                power_scale_reg <= cfg_data;
        end
    end

    // effective size, clamped to [2, MAX_BINS]
    logic [CW-1:0]                n_eff;
    logic [ospf_pkg::IDX_W-1:0]   dc;
    logic [CW-1:0]                idx_ext;
    logic [CW-1:0]                dc_ext;
    logic                         rd_err;
    logic                         wr_ok;
    logic [CW-1:0]                addr_a_next;
    logic [CW-1:0]                addr_b_next;
    logic                         pair_next;

    always_comb
    begin
        priority if (bin_count_reg < ospf_pkg::COUNT_MIN)
            n_eff = ospf_pkg::COUNT_MIN;
        else if (32'(bin_count_reg) > MAX_BINS)
            n_eff = CW'(MAX_BINS);
        else
            n_eff = bin_count_reg;
    end

    assign dc      = n_eff[CW-1:1];
    assign idx_ext = {1'b0, bin_index};
    assign dc_ext  = {1'b0, dc};
    assign rd_err  = bin_index > dc;
    assign wr_ok   = idx_ext < n_eff;

    always_comb
    begin
        priority if (bin_index == '0)
        begin
            addr_a_next = dc_ext;
            addr_b_next = dc_ext;
            pair_next   = 1'b0;
        end
        else if (bin_index == dc)
        begin
            addr_a_next = '0;
            addr_b_next = n_eff - CW'(1);
            pair_next   = n_eff[0];
        end
        else
        begin
            addr_a_next = dc_ext - idx_ext;
            addr_b_next = dc_ext + idx_ext;
            pair_next   = 1'b1;
        end
    end

    logic [AW-1:0] addr_a_reg;
    logic [AW-1:0] addr_b_reg;
    logic          pair_reg;
    logic          err_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_a_reg <= AW'(addr_a_next);
            addr_b_reg <= AW'(addr_b_next);
            pair_reg   <= pair_next;
            err_reg    <= rd_err;
        end
    end

    // bin store: one write, one registered read per cycle
    logic [DW-1:0] mem [MAX_BINS];
    logic [DW-1:0] rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] rd_addr;

    assign wr_en   = cmd.accept && (opcode == ospf_pkg::OP_WRITE) && wr_ok;
    assign rd_addr = cmd.fetch_b ? addr_b_reg : addr_a_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[AW'(bin_index)] <= {real_part, imag_part};
        if (cmd.fetch_a || cmd.fetch_b)
            rd_data_reg <= mem[rd_addr];
    end

    logic [DW-1:0] a_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.fetch_b)
            a_reg <= rd_data_reg;
    end

    // fold and square
    logic [DW-1:0]          b_val;
    logic signed [SB:0]     sum_re;
    logic signed [SB:0]     sum_im;
    logic signed [PW-1:0]   sq_re_full;
    logic signed [PW-1:0]   sq_im_full;
    logic [SQW-1:0]         sq_re_reg;
    logic [SQW-1:0]         sq_im_reg;

    assign b_val  = pair_reg ? rd_data_reg : '0;
    assign sum_re = {a_reg[DW-1], a_reg[DW-1:SB]} + {b_val[DW-1], b_val[DW-1:SB]};
    assign sum_im = {a_reg[SB-1], a_reg[SB-1:0]} + {b_val[SB-1], b_val[SB-1:0]};
    assign sq_re_full = sum_re * sum_re;
    assign sq_im_full = sum_im * sum_im;

    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            sq_re_reg <= sq_re_full[SQW-1:0];
            sq_im_reg <= sq_im_full[SQW-1:0];
        end
    end

    logic [PW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.add)
            p_reg <= PW'(sq_re_reg) + PW'(sq_im_reg);
    end

    // Q0.16 scale, split so each product stays narrow
    logic [PW-FW-1:0]  p_hi;
    logic [FW-1:0]     p_lo;
    logic [2*FW-1:0]   lo_full;
    logic [PW-1:0]     hi_prod_reg;
    logic [FW-1:0]     lo_prod_reg;

    assign p_hi    = p_reg[PW-1:FW];
    assign p_lo    = p_reg[FW-1:0];
    assign lo_full = (2*FW)'(p_lo) * (2*FW)'(power_scale_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            hi_prod_reg <= PW'(p_hi) * PW'(power_scale_reg);
            lo_prod_reg <= lo_full[2*FW-1:FW];
        end
    end

    logic [PW-1:0]                 total;
    logic                          rsp_valid_reg;
    logic [ospf_pkg::POWER_W-1:0]  power_reg;
    logic                          index_error_reg;

    assign total = hi_prod_reg + PW'(lo_prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.load)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            power_reg       <= err_reg ? '0 : ospf_pkg::POWER_W'(total);
            index_error_reg <= err_reg;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign power       = power_reg;
    assign index_error = index_error_reg;

    assign sts.is_read  = (opcode == ospf_pkg::OP_READ);
    assign sts.rd_err   = rd_err;
    assign sts.out_free = !rsp_valid_reg || !rsp_stall;

endmodule

`default_nettype wire

// ===== sv/ospf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ospf_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire ospf_pkg::sts_t sts,
    output ospf_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_FETCH_A = 3'd1;
    localparam logic [2:0] S_FETCH_B = 3'd2;
    localparam logic [2:0] S_SQUARE  = 3'd3;
    localparam logic [2:0] S_ADD     = 3'd4;
    localparam logic [2:0] S_SCALE   = 3'd5;
    localparam logic [2:0] S_LOAD    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && sts.is_read)
                    state_next = sts.rd_err ? S_LOAD : S_FETCH_A;
            end
            S_FETCH_A:
            begin
                cmd.fetch_a = 1'b1;
                state_next  = S_FETCH_B;
            end
            S_FETCH_B:
            begin
                cmd.fetch_b = 1'b1;
                state_next  = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== sv/one_sided_power_spectrum_fold.sv =====
// One-sided power spectrum fold.
// Request channel (req_valid/req_stall): opcode 0 writes one complex bin at a
// centered index, opcode 1 reads one-sided power bin bin_index. A beat moves
// when valid is high and stall is low.
// Response channel (rsp_valid/rsp_stall): one beat per read, none per write.
// power is the folded |X|^2 scaled by power_scale (Q0.16); index_error marks
// a read index above half the clamped bin count, with power zero.
// Config port: cfg_we with cfg_index 0 = bin_count, 1 = power_scale; write
// only while idle.
// Sequence: a write goes into the bin store at accept. A valid read passes
// fetch A, fetch B (two fetches from the single read port of the bin store),
// square, add, scale and load, and holds the request side until the result
// is loaded; an out-of-range read goes straight to load. One item is in work at
// a time; the next request is taken the cycle after the result is loaded.
// If the receiver stalls, a finished result waits in the scale registers and
// requests stay stalled until the output register frees up.
// Reset: clears control and loads bin_count 1024, power_scale 1311. The bin
// store is not cleared; bins must be written before they are read.
`timescale 1ns / 1ps
`default_nettype none

module one_sided_power_spectrum_fold #(
    parameter int MAX_BINS    = ospf_pkg::MAX_BINS_DEF,
    parameter int SAMPLE_BITS = ospf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [ospf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ospf_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire logic                              opcode,
    input  wire logic [ospf_pkg::IDX_W-1:0]        bin_index,
    input  wire logic signed [SAMPLE_BITS-1:0]     real_part,
    input  wire logic signed [SAMPLE_BITS-1:0]     imag_part,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output logic [ospf_pkg::POWER_W-1:0]           power,
    output logic                                   index_error
);

    ospf_pkg::cmd_t cmd;
    ospf_pkg::sts_t sts;

    ospf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ospf_dp #(
        .MAX_BINS    (MAX_BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .opcode      (opcode),
        .bin_index   (bin_index),
        .real_part   (real_part),
        .imag_part   (imag_part),
        .rsp_stall   (rsp_stall),
        .rsp_valid   (rsp_valid),
        .power       (power),
        .index_error (index_error),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 40;

    typedef struct packed {
        logic [ospf_pkg::POWER_W-1:0] power;
        logic                         index_error;
    } power_beat_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_we;
    logic [ospf_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [ospf_pkg::CFG_W-1:0]            cfg_data;
    logic                                  req_valid;
    logic                                  req_stall;
    logic                                  opcode;
    logic [ospf_pkg::IDX_W-1:0]            bin_index;
    logic signed [15:0]                    real_part;
    logic signed [15:0]                    imag_part;
    logic                                  rsp_valid;
    logic                                  rsp_stall;
    logic [ospf_pkg::POWER_W-1:0]          power;
    logic                                  index_error;

    // shadow of the block: bin store, written flags, registers
    logic signed [15:0]            shadow_re [ospf_pkg::MAX_BINS_DEF];
    logic signed [15:0]            shadow_im [ospf_pkg::MAX_BINS_DEF];
    bit                            bin_loaded [ospf_pkg::MAX_BINS_DEF];
    logic [ospf_pkg::COUNT_W-1:0]  count_reg;
    logic [ospf_pkg::SCALE_W-1:0]  scale_reg;

    power_beat_t         pending_power [$];
    int                  mismatches;
    int                  cycle_count;
    bit                  calm;

    one_sided_power_spectrum_fold i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .opcode     (opcode),
        .bin_index  (bin_index),
        .real_part  (real_part),
        .imag_part  (imag_part),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .power      (power),
        .index_error(index_error)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_stall <= !calm && ($urandom_range(99) < 18);
        end
    end

    function automatic int active_bins();
        int n;
        n = int'(count_reg);
        if (n < 2)
            n = 2;
        if (n > ospf_pkg::MAX_BINS_DEF)
            n = ospf_pkg::MAX_BINS_DEF;
        return n;
    endfunction

    function automatic power_beat_t fold_power(input int k);
        int                 n;
        int                 dc;
        longint             sr;
        longint             si;
        longint unsigned    p;
        power_beat_t        r;
        n = active_bins();
        dc = n / 2;
        r.power = '0;
        r.index_error = 1'b0;
        if (k > dc)
        begin
            r.index_error = 1'b1;
            return r;
        end
        if (k == 0)
        begin
            sr = shadow_re[dc];
            si = shadow_im[dc];
        end
        else if (k == dc)
        begin
            sr = shadow_re[0];
            si = shadow_im[0];
            if (n % 2 == 1)
            begin
                sr += shadow_re[n-1];
                si += shadow_im[n-1];
            end
        end
        else
        begin
            sr = longint'(shadow_re[dc-k]) + longint'(shadow_re[dc+k]);
            si = longint'(shadow_im[dc-k]) + longint'(shadow_im[dc+k]);
        end
        p = sr * sr + si * si;
        r.power = ospf_pkg::POWER_W'((p * longint'(scale_reg)) >> ospf_pkg::FRAC_W);
        return r;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        power_beat_t exp_beat;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_power.size() == 0)
            begin
                $error("response beat with nothing outstanding: power %0d index_error %0b",
                       power, index_error);
                mismatches++;
            end
            else
            begin
                exp_beat = pending_power.pop_front();
                if (power !== exp_beat.power)
                begin
                    $error("power expected %0d actual %0d", exp_beat.power, power);
                    mismatches++;
                end
                if (index_error !== exp_beat.index_error)
                begin
                    $error("index_error expected %0b actual %0b",
                           exp_beat.index_error, index_error);
                    mismatches++;
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_item(input logic op, input int idx,
                             input logic [15:0] re, input logic [15:0] im);
        while (!calm && $urandom_range(99) < 18)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        opcode    <= op;
        bin_index <= ospf_pkg::IDX_W'(idx);
        real_part <= re;
        imag_part <= im;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (op == ospf_pkg::OP_WRITE)
        begin
            if (idx < active_bins())
            begin
                shadow_re[idx]  = re;
                shadow_im[idx]  = im;
                bin_loaded[idx] = 1'b1;
            end
        end
        else
            pending_power.push_back(fold_power(idx));
        @(negedge clk);
    endtask

    task automatic load_bin(input int idx, input logic [15:0] re, input logic [15:0] im);
        send_item(ospf_pkg::OP_WRITE, idx, re, im);
    endtask

    task automatic fill_if_empty(input int b);
        if (!bin_loaded[b])
            load_bin(b, rand_sample(), rand_sample());
    endtask

    // loads any bin the fold would touch that has not been written yet
    task automatic read_bin(input int k);
        int n;
        int dc;
        n = active_bins();
        dc = n / 2;
        if (k == 0)
            fill_if_empty(dc);
        else if (k == dc)
        begin
            fill_if_empty(0);
            if (n % 2 == 1)
                fill_if_empty(n - 1);
        end
        else if (k < dc)
        begin
            fill_if_empty(dc - k);
            fill_if_empty(dc + k);
        end
        send_item(ospf_pkg::OP_READ, k, 16'($urandom), 16'($urandom));
    endtask

    task automatic wait_quiet();
        req_valid <= 1'b0;
        while (pending_power.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [ospf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ospf_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == ospf_pkg::REG_BIN_COUNT)
            count_reg = data[ospf_pkg::COUNT_W-1:0];
        else if (idx == ospf_pkg::REG_POWER_SCALE)
            scale_reg = data[ospf_pkg::SCALE_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_field_extremes();
        load_bin(512, 16'h8000, 16'h8000);
        read_bin(0);
        load_bin(0, 16'h7fff, 16'h8000);
        read_bin(512);
        load_bin(511, 16'h7fff, 16'h7fff);
        load_bin(513, 16'h7fff, 16'h7fff);
        read_bin(1);
        load_bin(1023, 16'h8000, 16'h7fff);
        read_bin(511);
        read_bin(513);
        read_bin(1023);
        wait_quiet();
    endtask

    task automatic test_odd_size();
        cfg_write(ospf_pkg::REG_POWER_SCALE, 16'hffff);
        cfg_write(ospf_pkg::REG_BIN_COUNT, 16'd3);
        load_bin(0, 16'h8000, 16'h8000);
        load_bin(2, 16'h8000, 16'h8000);
        read_bin(0);
        read_bin(1);
        read_bin(2);
        load_bin(3, 16'h1234, 16'h4321);
        load_bin(1000, 16'h7fff, 16'h0001);
        read_bin(1);
        wait_quiet();
    endtask

    task automatic test_size_saturation();
        cfg_write(ospf_pkg::REG_POWER_SCALE, 16'd0);
        cfg_write(ospf_pkg::REG_BIN_COUNT, 16'd0);
        read_bin(1);
        wait_quiet();
        cfg_write(ospf_pkg::REG_POWER_SCALE, 16'd1);
        read_bin(0);
        read_bin(2);
        wait_quiet();
        cfg_write(ospf_pkg::REG_BIN_COUNT, 16'hf801);
        read_bin(1);
        wait_quiet();
        cfg_write(ospf_pkg::REG_BIN_COUNT, 16'd2047);
        cfg_write(ospf_pkg::REG_POWER_SCALE, 16'd40000);
        read_bin(512);
        wait_quiet();
    endtask

    task automatic test_random_phases();
        int n;
        int dc;
        int k;
        logic [ospf_pkg::CFG_W-1:0] count_val;
        logic [ospf_pkg::CFG_W-1:0] scale_val;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: count_val = 16'($urandom_range(33, 2));
                4:       count_val = 16'($urandom_range(1, 0));
                5:       count_val = 16'd1024;
                6:       count_val = 16'($urandom_range(2047, 1025));
                7:       count_val = 16'($urandom_range(1024, 2));
                default: count_val = 16'($urandom_range(3, 2));
            endcase
            case ($urandom_range(4))
                0:       scale_val = 16'd0;
                1:       scale_val = 16'hffff;
                default: scale_val = 16'($urandom);
            endcase
            cfg_write(ospf_pkg::REG_BIN_COUNT, count_val);
            cfg_write(ospf_pkg::REG_POWER_SCALE, scale_val);
            calm = (ph == 4);
            n = active_bins();
            dc = n / 2;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(99) < 35)
                begin
                    if ($urandom_range(9) == 0)
                        load_bin($urandom_range(1023), rand_sample(), rand_sample());
                    else
                        load_bin($urandom_range(n - 1), rand_sample(), rand_sample());
                end
                else
                begin
                    if ($urandom_range(99) < 85)
                        k = $urandom_range(dc);
                    else
                        k = $urandom_range(1023);
                    read_bin(k);
                end
            end
            wait_quiet();
            calm = 1'b0;
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        req_valid   = 1'b0;
        opcode      = ospf_pkg::OP_WRITE;
        bin_index   = '0;
        real_part   = '0;
        imag_part   = '0;
        calm        = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        count_reg   = ospf_pkg::COUNT_RST;
        scale_reg   = ospf_pkg::SCALE_RST;
        for (int i = 0; i < ospf_pkg::MAX_BINS_DEF; i++)
        begin
            shadow_re[i]  = '0;
            shadow_im[i]  = '0;
            bin_loaded[i] = 1'b0;
        end
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_field_extremes();
        test_odd_size();
        test_size_saturation();
        test_random_phases();

        if (mismatches == 0 && pending_power.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
